/* sv/midpoint_ellipse_rasterizer_core_defines.svh */
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer assertion macros
// Concurrent check wrappers on clk / rst_n; empty when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef MIDPOINT_ELLIPSE_RASTERIZER_CORE_DEFINES_SVH
`define MIDPOINT_ELLIPSE_RASTERIZER_CORE_DEFINES_SVH

`ifndef SYNTHESIS
`define MER_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("mer: same-cycle check failed");
`define MER_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("mer: next-cycle check failed");
`else
`define MER_ASSERT_NOW(label, ante, cons)
`define MER_ASSERT_NEXT(label, ante, cons)
`endif

`endif

/* sv/mer_pkg.sv */
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer package
// Widths, register indexes, controller states and control/status bundles.
// ----------------------------------------------------------------------------
package mer_pkg;

    localparam int AXIS_BITS      = 11;
    localparam int COORD_BITS     = 12;
    localparam int PIX_BITS       = COORD_BITS + 2;
    localparam int DEC_BITS       = 48;
    localparam int CFG_IDX_BITS   = 2;
    localparam int CFG_DATA_BITS  = (COORD_BITS > AXIS_BITS) ? COORD_BITS : AXIS_BITS;
    localparam int IN_TDATA_BITS  = 8;
    localparam int OUT_TDATA_BITS = ((2 * PIX_BITS + 7) / 8) * 8;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_CENTER_X    = 2'd0,
        CFG_CENTER_Y    = 2'd1,
        CFG_SEMI_AXIS_X = 2'd2,
        CFG_SEMI_AXIS_Y = 2'd3
    } cfg_reg_t;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_RST_SQ,
        ST_RST_MUL,
        ST_RST_LOAD,
        ST_ADV_SQ,
        ST_ADV_MUL,
        ST_ADV_TEST,
        ST_R2_SQ,
        ST_R2_MUL,
        ST_R2_LOAD,
        ST_EMIT0,
        ST_EMIT1,
        ST_EMIT2,
        ST_EMIT3,
        ST_STEP,
        ST_UPD_MUL,
        ST_UPD_LOAD
    } state_t;

    typedef struct packed {
        logic       sq;
        logic       mul;
        logic       mul_init;
        logic       init_load;
        logic       r2_sq;
        logic       r2_mul;
        logic       r2_load;
        logic       emit;
        logic [1:0] emit_idx;
        logic       finish;
        logic       step;
        logic       upd_load;
    } cmd_t;

    typedef struct packed {
        logic finished;
        logic region_two;
        logic beyond;
        logic out_busy;
        logic at_axis;
    } status_t;

endpackage

/* sv/mer_ctrl.sv */
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer controller
// Sequences squares, products, region switch, pixel emission and the update.
// ----------------------------------------------------------------------------
module mer_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             req_valid,
    output logic             req_ready,
    input  logic             restart,
    input  mer_pkg::status_t status,
    output mer_pkg::cmd_t    cmd
);

    mer_pkg::state_t state_reg;
    mer_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= mer_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign req_ready = (state_reg == mer_pkg::ST_IDLE);

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            mer_pkg::ST_IDLE:
            begin
                if (req_valid)
                begin
                    if (restart)
                        state_next = mer_pkg::ST_RST_SQ;
                    else if (!status.finished)
                        state_next = mer_pkg::ST_ADV_SQ;
                end
            end
            mer_pkg::ST_RST_SQ:
            begin
                cmd.sq     = 1'b1;
                state_next = mer_pkg::ST_RST_MUL;
            end
            mer_pkg::ST_RST_MUL:
            begin
                cmd.mul      = 1'b1;
                cmd.mul_init = 1'b1;
                state_next   = mer_pkg::ST_RST_LOAD;
            end
            mer_pkg::ST_RST_LOAD:
            begin
                cmd.init_load = 1'b1;
                state_next    = mer_pkg::ST_IDLE;
            end
            mer_pkg::ST_ADV_SQ:
            begin
                cmd.sq     = 1'b1;
                state_next = mer_pkg::ST_ADV_MUL;
            end
            mer_pkg::ST_ADV_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = mer_pkg::ST_ADV_TEST;
            end
            mer_pkg::ST_ADV_TEST:
            begin
                if (!status.region_two && status.beyond)
                    state_next = mer_pkg::ST_R2_SQ;
                else
                    state_next = mer_pkg::ST_EMIT0;
            end
            mer_pkg::ST_R2_SQ:
            begin
                cmd.r2_sq  = 1'b1;
                state_next = mer_pkg::ST_R2_MUL;
            end
            mer_pkg::ST_R2_MUL:
            begin
                cmd.r2_mul = 1'b1;
                state_next = mer_pkg::ST_R2_LOAD;
            end
            mer_pkg::ST_R2_LOAD:
            begin
                cmd.r2_load = 1'b1;
                state_next  = mer_pkg::ST_EMIT0;
            end
            mer_pkg::ST_EMIT0:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_idx = 2'd0;
                    state_next   = mer_pkg::ST_EMIT1;
                end
            end
            mer_pkg::ST_EMIT1:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_idx = 2'd1;
                    state_next   = mer_pkg::ST_EMIT2;
                end
            end
            mer_pkg::ST_EMIT2:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_idx = 2'd2;
                    state_next   = mer_pkg::ST_EMIT3;
                end
            end
            mer_pkg::ST_EMIT3:
            begin
                if (!status.out_busy)
                begin
                    cmd.emit     = 1'b1;
                    cmd.emit_idx = 2'd3;
                    if (status.at_axis)
                    begin
                        cmd.finish = 1'b1;
                        state_next = mer_pkg::ST_IDLE;
                    end
                    else
                    begin
                        state_next = mer_pkg::ST_STEP;
                    end
                end
            end
            mer_pkg::ST_STEP:
            begin
                cmd.step   = 1'b1;
                state_next = mer_pkg::ST_UPD_MUL;
            end
            mer_pkg::ST_UPD_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = mer_pkg::ST_UPD_LOAD;
            end
            mer_pkg::ST_UPD_LOAD:
            begin
                cmd.upd_load = 1'b1;
                state_next   = mer_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = mer_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

/* sv/mer_datapath.sv */
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer datapath
// Config registers, point and decision state, multipliers, output register.
// ----------------------------------------------------------------------------
module mer_datapath (
    input  logic                                clk,
    input  logic                                rst_n,
    input  mer_pkg::cmd_t                       cmd,
    output mer_pkg::status_t                    status,
    input  logic                                cfg_we,
    input  logic [mer_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [mer_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mer_pkg::OUT_TDATA_BITS-1:0]  m_tdata,
    output logic                                m_tlast,
    output logic                                m_tuser
);

    localparam int AB   = mer_pkg::AXIS_BITS;
    localparam int CB   = mer_pkg::COORD_BITS;
    localparam int DB   = mer_pkg::DEC_BITS;
    localparam int PXB  = mer_pkg::PIX_BITS;
    localparam int SQB  = 2 * AB;
    localparam int YOPB = (AB > CB) ? AB : CB;
    localparam int PB   = SQB + YOPB;
    localparam int TXB  = CB + 1;
    localparam int TXSQ = 2 * TXB;
    localparam int TYSQ = 2 * CB;
    localparam int N1B  = SQB + TXSQ;
    localparam int N2B  = SQB + TYSQ;
    localparam int ABB  = 2 * SQB;

    logic [CB-1:0]   center_x_reg;
    logic [CB-1:0]   center_y_reg;
    logic [AB-1:0]   semi_x_reg;
    logic [AB-1:0]   semi_y_reg;

    logic [CB-1:0]   x_reg, x_next;
    logic [CB-1:0]   y_reg, y_next;
    logic [DB-1:0]   d_reg, d_next;
    logic            region_reg, region_next;
    logic            fin_reg, fin_next;
    logic            take_reg, take_next;
    logic            out_valid_reg;

    logic [SQB-1:0]  a2_reg, b2_reg;
    logic [PB-1:0]   bx_reg, ay_reg;
    logic [TXSQ-1:0] sqtx_reg;
    logic [TYSQ-1:0] sqty_reg;
    logic [ABB-1:0]  ab_reg;
    logic [N1B-1:0]  n1_reg;
    logic [N2B-1:0]  n2_reg;
    logic [PXB-1:0]  px_reg, py_reg;
    logic            last_reg, done_reg;

    logic [YOPB-1:0] mul_y;
    logic [TXB-1:0]  tx;
    logic [CB-1:0]   ty_abs;
    logic            d_neg, d_pos;
    logic [DB-1:0]   bx8, ay8, a24, b24;
    logic [PXB-1:0]  cx_ext, cy_ext, x_ext, y_ext;

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            semi_x_reg   <= AB'(1);
            semi_y_reg   <= AB'(1);
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                mer_pkg::CFG_CENTER_X:    center_x_reg <= cfg_data[CB-1:0];
                mer_pkg::CFG_CENTER_Y:    center_y_reg <= cfg_data[CB-1:0];
                mer_pkg::CFG_SEMI_AXIS_X: semi_x_reg   <= cfg_data[AB-1:0];
                mer_pkg::CFG_SEMI_AXIS_Y: semi_y_reg   <= cfg_data[AB-1:0];
                default: ;
            endcase
        end
    end

    assign mul_y  = cmd.mul_init ? YOPB'(semi_y_reg) : YOPB'(y_reg);
    assign tx     = {x_reg, 1'b1};
    assign ty_abs = (y_reg == '0) ? CB'(1) : (y_reg - CB'(1));

    // arithmetic pipeline registers
    always_ff @(posedge clk)
    begin
        if (cmd.sq)
        begin
            a2_reg <= SQB'(semi_x_reg) * SQB'(semi_x_reg);
            b2_reg <= SQB'(semi_y_reg) * SQB'(semi_y_reg);
        end
        if (cmd.mul)
        begin
            bx_reg <= PB'(b2_reg) * PB'(x_reg);
            ay_reg <= PB'(a2_reg) * PB'(mul_y);
        end
        if (cmd.r2_sq)
        begin
            sqtx_reg <= TXSQ'(tx) * TXSQ'(tx);
            sqty_reg <= TYSQ'(ty_abs) * TYSQ'(ty_abs);
            ab_reg   <= ABB'(a2_reg) * ABB'(b2_reg);
        end
        if (cmd.r2_mul)
        begin
            n1_reg <= N1B'(b2_reg) * N1B'(sqtx_reg);
            n2_reg <= N2B'(a2_reg) * N2B'(sqty_reg);
        end
    end

    assign d_neg = d_reg[DB-1];
    assign d_pos = !d_reg[DB-1] && (d_reg != '0);
    assign bx8   = DB'(bx_reg) << 3;
    assign ay8   = DB'(ay_reg) << 3;
    assign a24   = DB'(a2_reg) << 2;
    assign b24   = DB'(b2_reg) << 2;

    always_comb
    begin
        x_next      = x_reg;
        y_next      = y_reg;
        d_next      = d_reg;
        region_next = region_reg;
        fin_next    = fin_reg;
        take_next   = take_reg;
        if (cmd.init_load)
        begin
            x_next      = '0;
            y_next      = CB'(semi_y_reg);
            d_next      = b24 - (DB'(ay_reg) << 2) + DB'(a2_reg);
            region_next = 1'b0;
            fin_next    = 1'b0;
        end
        if (cmd.r2_load)
        begin
            d_next      = DB'(n1_reg) + (DB'(n2_reg) << 2) - (DB'(ab_reg) << 2);
            region_next = 1'b1;
        end
        if (cmd.step)
        begin
            // take: axis-only move, no diagonal
            take_next = region_reg ? d_pos : d_neg;
            if (!region_reg)
            begin
                x_next = x_reg + CB'(1);
                if (!d_neg)
                    y_next = y_reg - CB'(1);
            end
            else
            begin
                y_next = y_reg - CB'(1);
                if (!d_pos)
                    x_next = x_reg + CB'(1);
            end
        end
        if (cmd.upd_load)
        begin
            d_next = d_reg
                   + ((take_reg && region_reg) ? '0 : bx8)
                   - ((take_reg && !region_reg) ? '0 : ay8)
                   + (region_reg ? a24 : b24);
        end
        if (cmd.finish)
            fin_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg      <= '0;
            y_reg      <= '0;
            d_reg      <= '0;
            region_reg <= 1'b0;
            fin_reg    <= 1'b1;
            take_reg   <= 1'b0;
        end
        else
        begin
            x_reg      <= x_next;
            y_reg      <= y_next;
            d_reg      <= d_next;
            region_reg <= region_next;
            fin_reg    <= fin_next;
            take_reg   <= take_next;
        end
    end

    // output register
    assign cx_ext = PXB'(center_x_reg);
    assign cy_ext = PXB'(center_y_reg);
    assign x_ext  = PXB'(x_reg);
    assign y_ext  = PXB'(y_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.emit)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.emit)
        begin
            px_reg   <= cmd.emit_idx[0] ? (cx_ext - x_ext) : (cx_ext + x_ext);
            py_reg   <= cmd.emit_idx[1] ? (cy_ext - y_ext) : (cy_ext + y_ext);
            last_reg <= (cmd.emit_idx == 2'd3);
            done_reg <= (y_reg == '0);
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = mer_pkg::OUT_TDATA_BITS'({py_reg, px_reg});
    assign m_tlast  = last_reg;
    assign m_tuser  = done_reg;

    assign status.finished   = fin_reg;
    assign status.region_two = region_reg;
    assign status.beyond     = (bx_reg > ay_reg);
    assign status.out_busy   = out_valid_reg && !m_tready;
    assign status.at_axis    = (y_reg == '0);

endmodule

/* sv/midpoint_ellipse_rasterizer_core.sv */
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer core
// Two-region midpoint ellipse walker emitting four mirrored pixels per step.
// ----------------------------------------------------------------------------
// Set center and semi-axes on the cfg channel (always ready; write only while
// idle), send a request with restart set, then one request with restart clear
// per step: each returns four pixels (+x,+y), (-x,+y), (+x,-y), (-x,-y), the
// fourth with tlast; tuser marks the step that reaches y = 0, after which
// advance requests return nothing until the next restart. A restart runs the
// registered multiplies for the squares and initial products, then the decision
// load; an advance runs the squares and products, the region-two switch on the
// step that enters region two, one output-register load per pixel (held by any
// output stall) and, unless the step reaches y = 0, the step and decision update.
`include "midpoint_ellipse_rasterizer_core_defines.svh"

module midpoint_ellipse_rasterizer_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [mer_pkg::IN_TDATA_BITS-1:0]   s_tdata,   // [0] restart
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [mer_pkg::OUT_TDATA_BITS-1:0]  m_tdata,   // [13:0] pixel_x, [27:14] pixel_y
    output logic                                m_tlast,   // last_of_step
    output logic                                m_tuser,   // ellipse_done
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [mer_pkg::CFG_IDX_BITS-1:0]    cfg_index,
    input  logic [mer_pkg::CFG_DATA_BITS-1:0]   cfg_data
);

    mer_pkg::cmd_t    cmd;
    mer_pkg::status_t status;

    assign cfg_ready = 1'b1;

    mer_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (s_tvalid),
        .req_ready (s_tready),
        .restart   (s_tdata[0]),
        .status    (status),
        .cmd       (cmd)
    );

    mer_datapath u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .cfg_we    (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser)
    );

    `MER_ASSERT_NEXT(a_restart_busy, s_tvalid && s_tready && s_tdata[0], !s_tready)
    `MER_ASSERT_NOW(a_emit_slot_free, cmd.emit, !status.out_busy)
    `MER_ASSERT_NOW(a_region_two_once, cmd.r2_load, !status.region_two)
    `MER_ASSERT_NEXT(a_finish_sets, cmd.finish, status.finished && m_tvalid && m_tlast)

endmodule

/* tb/midpoint_ellipse_rasterizer_core_tb.sv */
// ----------------------------------------------------------------------------
// Midpoint ellipse rasterizer core testbench
// Drives restart/advance requests and register writes with random gaps and
// output stalls. A scoreboard walks the ellipse alongside the core and checks
// every mirrored pixel, its tlast and its tuser in order.
// ----------------------------------------------------------------------------
module midpoint_ellipse_rasterizer_core_tb;
    import mer_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE_CYCLES = 24;
    localparam int REQ_TARGET = 330;

    typedef struct packed {
        logic [PIX_BITS-1:0] x;
        logic [PIX_BITS-1:0] y;
        logic                last;
        logic                done;
    } pixel_t;

    class ellipse_scoreboard;
        logic [COORD_BITS-1:0] center_x;
        logic [COORD_BITS-1:0] center_y;
        logic [AXIS_BITS-1:0]  semi_x;
        logic [AXIS_BITS-1:0]  semi_y;
        logic [COORD_BITS-1:0] pos_x;
        logic [COORD_BITS-1:0] pos_y;
        logic signed [DEC_BITS-1:0] dec_val;
        bit                    in_r2;
        bit                    walk_done;
        pixel_t                pending_pixels[$];
        int                    errors;

        function new();
            center_x  = '0;
            center_y  = '0;
            semi_x    = AXIS_BITS'(1);
            semi_y    = AXIS_BITS'(1);
            pos_x     = '0;
            pos_y     = '0;
            dec_val   = '0;
            in_r2     = 1'b0;
            walk_done = 1'b1;
            errors    = 0;
        endfunction

        function void note_config(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] val);
            case (idx)
                CFG_CENTER_X:    center_x = val[COORD_BITS-1:0];
                CFG_CENTER_Y:    center_y = val[COORD_BITS-1:0];
                CFG_SEMI_AXIS_X: semi_x = val[AXIS_BITS-1:0];
                CFG_SEMI_AXIS_Y: semi_y = val[AXIS_BITS-1:0];
                default: ;
            endcase
        endfunction

        function void push_pixel(longint px, longint py, bit last, bit done);
            pixel_t p;
            p.x    = px[PIX_BITS-1:0];
            p.y    = py[PIX_BITS-1:0];
            p.last = last;
            p.done = done;
            pending_pixels.push_back(p);
        endfunction

        // Returns the number of pixels the request produces.
        function int note_request(bit restart);
            longint a, b, a2, b2, cx, cy, x, y, d, tx, ty;
            bit     at_end;
            a  = longint'(semi_x);
            b  = longint'(semi_y);
            a2 = a * a;
            b2 = b * b;
            cx = longint'(center_x);
            cy = longint'(center_y);
            if (restart)
            begin
                pos_x     = '0;
                pos_y     = b[COORD_BITS-1:0];
                in_r2     = 1'b0;
                walk_done = 1'b0;
                d         = 4 * b2 - 4 * a2 * b + a2;
                dec_val   = d[DEC_BITS-1:0];
                return 0;
            end
            if (walk_done)
                return 0;

            x = longint'(pos_x);
            y = longint'(pos_y);
            d = longint'(dec_val);
            if (!in_r2 && !(4 * b2 * x <= 4 * a2 * y))
            begin
                tx    = 2 * x + 1;
                ty    = y - 1;
                in_r2 = 1'b1;
                d     = b2 * tx * tx + 4 * a2 * ty * ty - 4 * a2 * b2;
            end

            at_end = (y <= 0);
            push_pixel(cx + x, cy + y, 1'b0, at_end);
            push_pixel(cx - x, cy + y, 1'b0, at_end);
            push_pixel(cx + x, cy - y, 1'b0, at_end);
            push_pixel(cx - x, cy - y, 1'b1, at_end);

            if (at_end)
            begin
                walk_done = 1'b1;
                dec_val   = d[DEC_BITS-1:0];
                return 4;
            end

            if (!in_r2)
            begin
                x = x + 1;
                if (d < 0)
                    d = d + 8 * b2 * x + 4 * b2;
                else
                begin
                    y = y - 1;
                    d = d + 8 * b2 * x - 8 * a2 * y + 4 * b2;
                end
            end
            else
            begin
                y = y - 1;
                if (d > 0)
                    d = d + 4 * a2 - 8 * a2 * y;
                else
                begin
                    x = x + 1;
                    d = d + 8 * b2 * x - 8 * a2 * y + 4 * a2;
                end
            end
            pos_x   = x[COORD_BITS-1:0];
            pos_y   = y[COORD_BITS-1:0];
            dec_val = d[DEC_BITS-1:0];
            return 4;
        endfunction

        task report(string msg);
            $display("mismatch: %s", msg);
            errors++;
        endtask

        task check_pixel(pixel_t got);
            pixel_t want;
            if (pending_pixels.size() == 0)
            begin
                report($sformatf("unexpected pixel x=%0d y=%0d",
                                 $signed(got.x), $signed(got.y)));
                return;
            end
            want = pending_pixels.pop_front();
            if (got.x !== want.x)
                report($sformatf("pixel_x %0d, want %0d", $signed(got.x), $signed(want.x)));
            if (got.y !== want.y)
                report($sformatf("pixel_y %0d, want %0d", $signed(got.y), $signed(want.y)));
            if (got.last !== want.last)
                report($sformatf("last_of_step %b, want %b", got.last, want.last));
            if (got.done !== want.done)
                report($sformatf("ellipse_done %b, want %b", got.done, want.done));
        endtask

        function int pending();
            return pending_pixels.size();
        endfunction
    endclass

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [IN_TDATA_BITS-1:0]  s_tdata = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_tdata;
    logic                      m_tlast;
    logic                      m_tuser;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_IDX_BITS-1:0]   cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    ellipse_scoreboard sb;
    int unsigned       cycle_count = 0;
    int                req_count = 0;
    bit                tx_flat = 1'b0;
    bit                rx_flat = 1'b0;

    midpoint_ellipse_rasterizer_core u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    always #6 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    task automatic send_req(input bit restart);
        int gap;
        int n;
        gap = tx_flat ? 0 : $urandom_range(0, 11);
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {{(IN_TDATA_BITS-1){1'b0}}, restart};
        do @(posedge clk); while (s_tready !== 1'b1);
        n = sb.note_request(restart);
        if (restart || n > 0)
            req_count++;
    endtask

    task automatic write_reg(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        sb.note_config(idx, val);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Hold requests until every pixel is back.
    task automatic drain_results();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (sb.pending() != 0);
    endtask

    // Core idle: nothing outstanding, plus time for a request that emits nothing.
    task automatic idle_wait();
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [CFG_DATA_BITS-1:0] pick_axis();
        int r;
        r = $urandom_range(0, 9);
        if (r < 7)
            return CFG_DATA_BITS'($urandom_range(1, 12));
        if (r == 7)
            return CFG_DATA_BITS'($urandom_range(13, 60));
        if (r == 8)
            return CFG_DATA_BITS'($urandom_range(1024, 2047));
        return CFG_DATA_BITS'($urandom_range(0, 4095));
    endfunction

    initial
    begin : pixel_sink
        int     stall;
        pixel_t got;
        wait (rst_n === 1'b1);
        forever
        begin
            stall = rx_flat ? 0 : $urandom_range(0, 11);
            if (stall > 0)
            begin
                m_tready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
            got.x    = m_tdata[PIX_BITS-1:0];
            got.y    = m_tdata[2*PIX_BITS-1:PIX_BITS];
            got.last = m_tlast;
            got.done = m_tuser;
            sb.check_pixel(got);
        end
    end

    initial
    begin : watchdog
        while (cycle_count < CYCLE_LIMIT) @(posedge clk);
        $display("TB_ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int steps;
        int kind;
        int cap;
        sb = new();
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // advance right after reset: nothing to draw
        send_req(1'b0);

        // largest ellipse at the far corner, partial walk
        idle_wait();
        write_reg(CFG_CENTER_X, 12'd4095);
        write_reg(CFG_CENTER_Y, 12'd4095);
        write_reg(CFG_SEMI_AXIS_X, 12'd2047);
        write_reg(CFG_SEMI_AXIS_Y, 12'd2047);
        send_req(1'b1);
        repeat (3) send_req(1'b0);

        // move center to origin mid-walk: negative coordinates
        idle_wait();
        write_reg(CFG_CENTER_X, 12'd0);
        write_reg(CFG_CENTER_Y, 12'd0);
        repeat (2) send_req(1'b0);

        // zero horizontal axis via truncated write, then advance past the end
        idle_wait();
        write_reg(CFG_SEMI_AXIS_X, 12'd2048);
        write_reg(CFG_SEMI_AXIS_Y, 12'd3);
        send_req(1'b1);
        repeat (5) send_req(1'b0);

        // zero vertical axis: first point already ends the walk
        idle_wait();
        write_reg(CFG_SEMI_AXIS_X, 12'd3);
        write_reg(CFG_SEMI_AXIS_Y, 12'd2048);
        send_req(1'b1);
        repeat (2) send_req(1'b0);

        // unit circle, then restart while finished
        idle_wait();
        write_reg(CFG_SEMI_AXIS_X, 12'd1);
        write_reg(CFG_SEMI_AXIS_Y, 12'd1);
        send_req(1'b1);
        repeat (2) send_req(1'b0);
        send_req(1'b1);
        send_req(1'b0);

        while (req_count < REQ_TARGET)
        begin
            idle_wait();
            tx_flat = ($urandom_range(0, 3) == 0);
            rx_flat = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 1))
                write_reg(CFG_CENTER_X, CFG_DATA_BITS'($urandom_range(0, 4095)));
            if ($urandom_range(0, 1))
                write_reg(CFG_CENTER_Y, CFG_DATA_BITS'($urandom_range(0, 4095)));
            if ($urandom_range(0, 1))
                write_reg(CFG_SEMI_AXIS_X, pick_axis());
            if ($urandom_range(0, 1))
                write_reg(CFG_SEMI_AXIS_Y, pick_axis());

            kind = $urandom_range(0, 9);
            cap  = (sb.semi_x > 60 || sb.semi_y > 60) ? 30 : 150;
            if (kind < 8)
            begin
                send_req(1'b1);
                steps = 0;
                while (!sb.walk_done && steps < cap && req_count < REQ_TARGET)
                begin
                    if ($urandom_range(0, 15) == 0)
                        drain_results();
                    send_req(1'b0);
                    steps++;
                end
                repeat ($urandom_range(0, 2)) send_req(1'b0);
            end
            else if (kind == 8)
            begin
                send_req(1'b1);
                repeat ($urandom_range(1, 8)) send_req(1'b0);
            end
            else
                repeat ($urandom_range(1, 4)) send_req($urandom_range(0, 7) == 0);
        end

        idle_wait();
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
